// ===== rtl/wpsteer_pkg.sv =====
// Package for the waypoint heading steer block: payload types, fixed-point
// constants, CORDIC arctangent table and sequencer state codes.
// No dependencies.
package wpsteer_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 24;

  localparam int unsigned PosW   = 32;
  localparam int unsigned AngW   = 16;
  localparam int unsigned SpeedW = 31;
  localparam int unsigned TolW   = 15;
  localparam int unsigned CfgW   = 31;
  localparam int unsigned CfgIdxW = 2;

  // CORDIC datapath widths
  localparam int unsigned CxW   = 37;   // x,y with gain and prerotation
  localparam int unsigned CzW   = 29;   // angle, 2^24 scale
  localparam int unsigned DistW = 35;
  localparam int unsigned NumW  = 64;
  localparam int unsigned RemW  = 36;
  localparam int unsigned KinvW = 30;

  localparam logic [KinvW-1:0] KinvQ30 = 30'd652032874;
  localparam logic signed [CzW-1:0] HalfPiZ = 29'sd26353589;
  localparam logic signed [17:0] AngPi  = 18'sd25736;
  localparam logic signed [17:0] Ang2Pi = 18'sd51472;

  typedef enum logic [1:0] {
    REQ_MOVE = 2'd0,
    REQ_TURN = 2'd1,
    REQ_NOP2 = 2'd2,
    REQ_NOP3 = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_DRIVE_SPEED = 2'd0,
    CFG_ARRIVE_RAD  = 2'd1,
    CFG_HEAD_TOL    = 2'd2,
    CFG_TURN_STEP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROT  = 6'b000010,
    S_DIST = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [PosW-1:0]   target_x;
    logic signed [PosW-1:0]   target_y;
    logic signed [PosW-1:0]   position_x;
    logic signed [PosW-1:0]   position_y;
  } cmd_t;

  typedef struct packed {
    logic signed [PosW-1:0]   vel_x;
    logic signed [PosW-1:0]   vel_y;
    logic signed [AngW-1:0]   heading_out;
    logic                     done_res;
  } res_t;

  // atan(2^-i) scaled by 2^24
  function automatic logic [23:0] atan_lut(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/wpsteer_stream_if.sv =====
// Valid/ready stream interface used by both channels of the steer block.
// Payload type is a parameter; types come from wpsteer_pkg.
interface wpsteer_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/waypoint_heading_steer.sv =====
// Waypoint heading steer, top level and sole datapath.
// Uses wpsteer_pkg types/constants and wpsteer_stream_if channels.
//
// Usage:
//  - cmd_i: one transaction per control tick (request, target, position).
//  - res_o: exactly one transaction per command: velocity, heading, done.
//  - cfg_*: write port for drive_speed, arrive_radius, heading_tolerance,
//    turn_step; write only while the block is idle.
// Processing:
//  - Requests 2/3: no computation; they go straight from accept to S_DONE.
//  - Turn, or move that has arrived: the one-iteration-per-cycle CORDIC
//    (S_ROT), then the bit-serial 30-bit constant multiply that scales the
//    magnitude (S_DIST), then the result.
//  - Move not arrived: then also S_MUL and the two bit-serial restoring
//    dividers that run side by side (S_DIV).
//  - One command in flight; cmd_i.ready is high only in idle.
// Reset: heading and velocity clear to zero, registers take default values.
// Stall: the result sits in an output register; the next command is accepted
// and processed, and only its commit waits for the output slot to free.
module waypoint_heading_steer #(
  parameter int unsigned CORDIC_STEPS = wpsteer_pkg::CordicStepsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  wpsteer_stream_if.sink   cmd_i,
  wpsteer_stream_if.source res_o,
  input  logic                          cfg_we_i,
  input  logic [wpsteer_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [wpsteer_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned CxW   = wpsteer_pkg::CxW;
  localparam int unsigned CzW   = wpsteer_pkg::CzW;
  localparam int unsigned DistW = wpsteer_pkg::DistW;
  localparam int unsigned NumW  = wpsteer_pkg::NumW;
  localparam int unsigned RemW  = wpsteer_pkg::RemW;
  localparam int unsigned KinvW = wpsteer_pkg::KinvW;
  localparam logic [6:0] LastRot = 7'(CORDIC_STEPS - 1);

  // ---------------- configuration registers
  logic [30:0] speed_q, radius_q;
  logic [14:0] tol_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= 31'd655360;
      radius_q <= 31'd655;
      tol_q    <= 15'd410;
      step_q   <= 15'd819;
    end else if (cfg_we_i) begin
      case (wpsteer_pkg::cfg_idx_e'(cfg_idx_i))
        wpsteer_pkg::CFG_DRIVE_SPEED: speed_q  <= cfg_wdata_i;
        wpsteer_pkg::CFG_ARRIVE_RAD:  radius_q <= cfg_wdata_i;
        wpsteer_pkg::CFG_HEAD_TOL:    tol_q    <= cfg_wdata_i[14:0];
        wpsteer_pkg::CFG_TURN_STEP:   step_q   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer and working registers
  wpsteer_pkg::state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;

  logic [1:0]             req_q, req_d;
  logic signed [32:0]     dx_q, dx_d, dy_q, dy_d;
  logic                   zero_q, zero_d;
  logic signed [CxW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [CzW-1:0]  cz_q, cz_d;
  logic [65:0]            acc_q, acc_d;
  logic [DistW-1:0]       div_q, div_d;
  logic                   arrived_q, arrived_d;
  logic                   upd_vel_q, upd_vel_d;
  logic [NumW-1:0]        numx_q, numx_d, numy_q, numy_d;
  logic [RemW-1:0]        remx_q, remx_d, remy_q, remy_d;
  logic [31:0]            qx_q, qx_d, qy_q, qy_d;
  logic                   ovfx_q, ovfx_d, ovfy_q, ovfy_d;

  // architectural state
  logic signed [15:0]     heading_q, heading_d;
  logic signed [31:0]     velx_q, velx_d, vely_q, vely_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  wpsteer_pkg::res_t      out_q, out_d;

  // ---- combinational helpers
  logic signed [CxW-1:0]  sh_x, sh_y;
  logic signed [CzW-1:0]  atan_v;
  logic [65:0]            acc_step;
  logic [DistW-1:0]       dist_w;
  logic [32:0]            magx, magy;
  logic [RemW:0]          rsx, rsy;
  logic                   gex, gey;
  logic signed [CzW-1:0]  z_rnd;
  logic signed [17:0]     ang_raw, ang, hd, diff, absd, hstep, hnew;
  logic                   aligned, commit, act;
  logic [31:0]            satx, saty;

  function automatic logic [31:0] sat_comp(input logic neg, input logic ovf,
                                           input logic [31:0] q);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
      else                          r = 32'd0 - q;
    end else begin
      if (ovf || q[31]) r = 32'h7FFF_FFFF;
      else              r = q;
    end
    return r;
  endfunction

  assign cmd_i.ready = (state_q == wpsteer_pkg::S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  always_comb begin
    sh_x   = cx_q >>> cnt_q[4:0];
    sh_y   = cy_q >>> cnt_q[4:0];
    atan_v = CzW'($signed({1'b0, wpsteer_pkg::atan_lut(cnt_q[4:0])}));
    // magnitude times 1/K, one constant bit per cycle, MSB first
    acc_step = {acc_q[64:0], 1'b0} +
               ((wpsteer_pkg::KinvQ30[cnt_q[4:0]] && (cx_q > 0)) ?
                66'(cx_q) : 66'd0);
    dist_w = acc_step[64:30];
    magx   = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
    magy   = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
    rsx    = {remx_q, numx_q[NumW-1]};
    rsy    = {remy_q, numy_q[NumW-1]};
    gex    = rsx >= {2'b00, div_q};
    gey    = rsy >= {2'b00, div_q};
    // bearing: round half up to Q3.13, clamp
    z_rnd   = cz_q + CzW'(1024);
    ang_raw = 18'(z_rnd >>> 11);
    if (zero_q)                           ang = '0;
    else if (ang_raw > wpsteer_pkg::AngPi)  ang = wpsteer_pkg::AngPi;
    else if (ang_raw < -wpsteer_pkg::AngPi) ang = -wpsteer_pkg::AngPi;
    else                                  ang = ang_raw;
    hd    = 18'(heading_q);
    diff  = hd - ang;
    absd  = diff[17] ? -diff : diff;
    aligned = absd < $signed({3'b000, tol_q});
    hstep = (ang - hd > 0) ? $signed({3'b000, step_q}) : -$signed({3'b000, step_q});
    hnew  = hd + hstep;
    if (hnew > wpsteer_pkg::AngPi)        hnew = hnew - wpsteer_pkg::Ang2Pi;
    else if (hnew <= -wpsteer_pkg::AngPi) hnew = hnew + wpsteer_pkg::Ang2Pi;
    satx = sat_comp(dx_q[32], ovfx_q, qx_q);
    saty = sat_comp(dy_q[32], ovfy_q, qy_q);
    act  = (req_q == wpsteer_pkg::REQ_MOVE) || (req_q == wpsteer_pkg::REQ_TURN);
    commit = (state_q == wpsteer_pkg::S_DONE) && (!out_valid_q || res_o.ready);
  end

  always_comb begin
    state_d = state_q;   cnt_d = cnt_q;
    req_d = req_q;       dx_d = dx_q;       dy_d = dy_q;   zero_d = zero_q;
    cx_d = cx_q;         cy_d = cy_q;       cz_d = cz_q;   acc_d = acc_q;
    div_d = div_q;       arrived_d = arrived_q;            upd_vel_d = upd_vel_q;
    numx_d = numx_q;     numy_d = numy_q;   remx_d = remx_q; remy_d = remy_q;
    qx_d = qx_q;         qy_d = qy_q;       ovfx_d = ovfx_q; ovfy_d = ovfy_q;
    heading_d = heading_q; velx_d = velx_q; vely_d = vely_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d = out_q;

    case (state_q)
      wpsteer_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          req_d  = cmd_i.data.req_type;
          dx_d   = 33'(cmd_i.data.target_x) - 33'(cmd_i.data.position_x);
          dy_d   = 33'(cmd_i.data.target_y) - 33'(cmd_i.data.position_y);
          zero_d = (dx_d == '0) && (dy_d == '0);
          // quadrant prerotation
          if (!dx_d[32]) begin
            cx_d = CxW'(dx_d); cy_d = CxW'(dy_d); cz_d = '0;
          end else if (!dy_d[32]) begin
            cx_d = CxW'(dy_d); cy_d = -CxW'(dx_d); cz_d = wpsteer_pkg::HalfPiZ;
          end else begin
            cx_d = -CxW'(dy_d); cy_d = CxW'(dx_d); cz_d = -wpsteer_pkg::HalfPiZ;
          end
          upd_vel_d = 1'b0;
          arrived_d = 1'b0;
          cnt_d     = '0;
          if ((cmd_i.data.req_type == wpsteer_pkg::REQ_MOVE) ||
              (cmd_i.data.req_type == wpsteer_pkg::REQ_TURN)) begin
            state_d = wpsteer_pkg::S_ROT;
          end else begin
            state_d = wpsteer_pkg::S_DONE;
          end
        end
      end
      wpsteer_pkg::S_ROT: begin
        if (!cy_q[CxW-1]) begin
          cx_d = cx_q + sh_y; cy_d = cy_q - sh_x; cz_d = cz_q + atan_v;
        end else begin
          cx_d = cx_q - sh_y; cy_d = cy_q + sh_x; cz_d = cz_q - atan_v;
        end
        if (cnt_q == LastRot) begin
          cnt_d   = 7'(KinvW - 1);
          acc_d   = '0;
          state_d = wpsteer_pkg::S_DIST;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      wpsteer_pkg::S_DIST: begin
        acc_d = acc_step;
        if (cnt_q == '0) begin
          arrived_d = {1'b0, dist_w} < {5'b0, radius_q};
          div_d     = (dist_w == '0) ? DistW'(1) : dist_w;
          if ((req_q == wpsteer_pkg::REQ_MOVE) &&
              !({1'b0, dist_w} < {5'b0, radius_q})) begin
            state_d = wpsteer_pkg::S_MUL;
          end else begin
            state_d = wpsteer_pkg::S_DONE;
          end
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      wpsteer_pkg::S_MUL: begin
        numx_d = NumW'(speed_q) * NumW'(magx);
        numy_d = NumW'(speed_q) * NumW'(magy);
        remx_d = '0;  remy_d = '0;
        qx_d   = '0;  qy_d   = '0;
        ovfx_d = 1'b0; ovfy_d = 1'b0;
        cnt_d  = 7'(NumW - 1);
        state_d = wpsteer_pkg::S_DIV;
      end
      wpsteer_pkg::S_DIV: begin
        remx_d = gex ? RemW'(rsx - {2'b00, div_q}) : RemW'(rsx);
        remy_d = gey ? RemW'(rsy - {2'b00, div_q}) : RemW'(rsy);
        numx_d = {numx_q[NumW-2:0], 1'b0};
        numy_d = {numy_q[NumW-2:0], 1'b0};
        qx_d   = {qx_q[30:0], gex};
        qy_d   = {qy_q[30:0], gey};
        ovfx_d = ovfx_q | (gex & (cnt_q >= 7'd32));
        ovfy_d = ovfy_q | (gey & (cnt_q >= 7'd32));
        if (cnt_q == '0) begin
          upd_vel_d = 1'b1;
          state_d   = wpsteer_pkg::S_DONE;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      wpsteer_pkg::S_DONE: begin
        if (commit) begin
          if (upd_vel_q) begin
            velx_d = satx;
            vely_d = saty;
          end
          if (act && !aligned) heading_d = 16'(hnew);
          out_valid_d       = 1'b1;
          out_d.vel_x       = upd_vel_q ? satx : velx_q;
          out_d.vel_y       = upd_vel_q ? saty : vely_q;
          out_d.heading_out = (act && !aligned) ? 16'(hnew) : heading_q;
          if (req_q == wpsteer_pkg::REQ_MOVE)      out_d.done_res = aligned && arrived_q;
          else if (req_q == wpsteer_pkg::REQ_TURN) out_d.done_res = aligned;
          else                                     out_d.done_res = 1'b0;
          state_d = wpsteer_pkg::S_IDLE;
        end
      end
      default: state_d = wpsteer_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpsteer_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
      velx_q      <= '0;
      vely_q      <= '0;
      upd_vel_q   <= 1'b0;
      arrived_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      heading_q   <= heading_d;
      velx_q      <= velx_d;
      vely_q      <= vely_d;
      upd_vel_q   <= upd_vel_d;
      arrived_q   <= arrived_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;   dx_q <= dx_d;   dy_q <= dy_d;   zero_q <= zero_d;
    cx_q   <= cx_d;    cy_q <= cy_d;   cz_q <= cz_d;   acc_q  <= acc_d;
    div_q  <= div_d;
    numx_q <= numx_d;  numy_q <= numy_d;
    remx_q <= remx_d;  remy_q <= remy_d;
    qx_q   <= qx_d;    qy_q   <= qy_d;
    ovfx_q <= ovfx_d;  ovfy_q <= ovfy_d;
    out_q  <= out_d;
  end

endmodule

// ===== tb/wpsteer_steer_checker.sv =====
// Checker for the waypoint heading steer block: predicts each result from
// the accepted commands and register writes, and compares field by field.
// Depends on wpsteer_pkg.
module wpsteer_steer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  logic                cmd_ready_i,
  input  wpsteer_pkg::cmd_t   cmd_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  wpsteer_pkg::res_t   res_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_wdata_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int Steps = wpsteer_pkg::CordicStepsDef;
  localparam longint AngPiL = 25736;
  localparam longint Ang2PiL = 51472;
  localparam longint HalfPiL = 26353589;
  localparam longint unsigned KinvL = 652032874;

  longint unsigned speed, radius, tol, step;
  longint heading, vel_x, vel_y;
  wpsteer_pkg::res_t expected_q[$];

  function automatic longint atan_val(int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // bearing and distance by CORDIC vectoring
  function automatic void bearing_dist(input longint dx, input longint dy,
                                       output longint ang,
                                       output longint unsigned span);
    longint x, y, z, nx, ny;
    if (dx == 0 && dy == 0) begin
      ang = 0;
      span = 0;
      return;
    end
    if (dx >= 0) begin
      x = dx; y = dy; z = 0;
    end else if (dy >= 0) begin
      x = dy; y = -dx; z = HalfPiL;
    end else begin
      x = -dy; y = dx; z = -HalfPiL;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_val(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_val(i);
      end
      x = nx; y = ny;
    end
    ang = ((z + 134218752) >>> 11) - 65536;
    if (ang > AngPiL) ang = AngPiL;
    if (ang < -AngPiL) ang = -AngPiL;
    span = (x > 0) ? ((longint'(x) * KinvL) >> 30) : 0;
  endfunction

  function automatic longint speed_part(longint d, longint unsigned div);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : d;
    q = (speed * mag) / div;
    if (d < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  function automatic bit steer_heading(longint ang);
    longint diff, h;
    diff = heading - ang;
    if (diff < 0) diff = -diff;
    if (diff < longint'(tol)) return 1'b1;
    h = heading + (((ang - heading) > 0) ? longint'(step) : -longint'(step));
    if (h > AngPiL) h -= Ang2PiL;
    else if (h <= -AngPiL) h += Ang2PiL;
    heading = h;
    return 1'b0;
  endfunction

  function automatic wpsteer_pkg::res_t predict_tick(wpsteer_pkg::cmd_t c);
    wpsteer_pkg::res_t r;
    longint dx, dy, ang;
    longint unsigned span;
    bit arrived, aligned, done;
    done = 1'b0;
    if (wpsteer_pkg::req_e'(c.req_type) == wpsteer_pkg::REQ_MOVE ||
        wpsteer_pkg::req_e'(c.req_type) == wpsteer_pkg::REQ_TURN) begin
      dx = longint'(c.target_x) - longint'(c.position_x);
      dy = longint'(c.target_y) - longint'(c.position_y);
      bearing_dist(dx, dy, ang, span);
      if (wpsteer_pkg::req_e'(c.req_type) == wpsteer_pkg::REQ_MOVE) begin
        arrived = span < radius;
        if (!arrived) begin
          vel_x = speed_part(dx, (span == 0) ? 1 : span);
          vel_y = speed_part(dy, (span == 0) ? 1 : span);
        end
        aligned = steer_heading(ang);
        done = aligned && arrived;
      end else begin
        done = steer_heading(ang);
      end
    end
    r.vel_x = vel_x[31:0];
    r.vel_y = vel_y[31:0];
    r.heading_out = heading[15:0];
    r.done_res = done;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    wpsteer_pkg::res_t e;
    if (!rst_ni) begin
      speed = 655360; radius = 655; tol = 410; step = 819;
      heading = 0; vel_x = 0; vel_y = 0;
      expected_q.delete();
      fail_cnt_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (wpsteer_pkg::cfg_idx_e'(cfg_idx_i))
          wpsteer_pkg::CFG_DRIVE_SPEED: speed = 64'(cfg_wdata_i);
          wpsteer_pkg::CFG_ARRIVE_RAD:  radius = 64'(cfg_wdata_i);
          wpsteer_pkg::CFG_HEAD_TOL:    tol = 64'(cfg_wdata_i[14:0]);
          wpsteer_pkg::CFG_TURN_STEP:   step = 64'(cfg_wdata_i[14:0]);
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) expected_q.push_back(predict_tick(cmd_data_i));
      if (res_valid_i && res_ready_i) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          $error("result with no pending expectation");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (res_data_i !== e) fail_cnt_o <= fail_cnt_o + 1;
          if (res_data_i.vel_x !== e.vel_x)
            $error("vel_x exp %0d got %0d", e.vel_x, res_data_i.vel_x);
          if (res_data_i.vel_y !== e.vel_y)
            $error("vel_y exp %0d got %0d", e.vel_y, res_data_i.vel_y);
          if (res_data_i.heading_out !== e.heading_out)
            $error("heading_out exp %0d got %0d", e.heading_out, res_data_i.heading_out);
          if (res_data_i.done_res !== e.done_res)
            $error("done_res exp %0d got %0d", e.done_res, res_data_i.done_res);
        end
      end
    end
  end
endmodule

// ===== tb/tb_waypoint_heading_steer.sv =====
// Top of the waypoint heading steer testbench: clock, reset, register
// phases and command stimulus; verdict from wpsteer_steer_checker.
// Depends on wpsteer_pkg, wpsteer_stream_if and the steer block.
module tb_waypoint_heading_steer;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [wpsteer_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [wpsteer_pkg::CfgW-1:0] cfg_wdata_i = '0;
  int fail_cnt, pending, checked;
  int sent_cnt = 0;
  logic stall_mode = 1'b0;

  wpsteer_stream_if #(.T(wpsteer_pkg::cmd_t)) cmd_ch ();
  wpsteer_stream_if #(.T(wpsteer_pkg::res_t)) res_ch ();

  waypoint_heading_steer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_ch.sink), .res_o(res_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  wpsteer_steer_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cmd_valid_i(cmd_ch.valid), .cmd_ready_i(cmd_ch.ready), .cmd_data_i(cmd_ch.data),
    .res_valid_i(res_ch.valid), .res_ready_i(res_ch.ready), .res_data_i(res_ch.data),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Receiver: stretches of always-ready alternate with random stalling.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= ~stall_mode;
    res_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // Hard stop, well past the slowest legal run.
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  int burst_left = 0;

  // One command transaction; the sender idles between random bursts.
  // valid stays high across a burst and drops only for a gap.
  task automatic send_cmd(input wpsteer_pkg::req_e req, input logic [31:0] tx,
                          input logic [31:0] ty,
                          input logic [31:0] px, input logic [31:0] py);
    wpsteer_pkg::cmd_t c;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    c.req_type = req;
    c.target_x = tx; c.target_y = ty; c.position_x = px; c.position_y = py;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sent_cnt++;
  endtask

  task automatic write_reg(input wpsteer_pkg::cfg_idx_e idx, input logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Registers change only once nothing is in flight.
  task automatic quiesce();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [30:0] spd, input logic [30:0] rad,
                          input logic [14:0] tl, input logic [14:0] stp);
    quiesce();
    write_reg(wpsteer_pkg::CFG_DRIVE_SPEED, spd);
    write_reg(wpsteer_pkg::CFG_ARRIVE_RAD, rad);
    write_reg(wpsteer_pkg::CFG_HEAD_TOL, tl);
    write_reg(wpsteer_pkg::CFG_TURN_STEP, stp);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly move/turn ticks; the target is often near the position so that
  // arrival, small-offset bearings and full-range differences all occur.
  task automatic random_ticks(input int n);
    logic [31:0] tx, ty, px, py;
    int r;
    wpsteer_pkg::req_e req;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      req = (r < 10) ? wpsteer_pkg::REQ_MOVE :
            (r < 17) ? wpsteer_pkg::REQ_TURN :
                       wpsteer_pkg::req_e'($urandom_range(2, 3));
      px = $urandom; py = $urandom;
      case ($urandom_range(0, 3))
        0: begin tx = $urandom; ty = $urandom; end
        1: begin
          tx = px + $signed($urandom_range(0, 4000) - 2000);
          ty = py + $signed($urandom_range(0, 4000) - 2000);
        end
        2: begin
          tx = px + ($signed($urandom) >>> $urandom_range(0, 20));
          ty = py + ($signed($urandom) >>> $urandom_range(0, 20));
        end
        default: begin tx = px; ty = py + $urandom_range(0, 1); end
      endcase
      send_cmd(req, tx, ty, px, py);
    end
  endtask

  localparam logic [31:0] PMax = 32'h7FFF_FFFF;
  localparam logic [31:0] PMin = 32'h8000_0000;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every request code, zero difference, all quadrants, extremes.
    send_cmd(wpsteer_pkg::REQ_MOVE, 0, 0, 0, 0);
    send_cmd(wpsteer_pkg::REQ_TURN, 0, 0, 0, 0);
    send_cmd(wpsteer_pkg::REQ_NOP2, PMax, PMin, PMin, PMax);
    send_cmd(wpsteer_pkg::REQ_NOP3, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
    send_cmd(wpsteer_pkg::REQ_MOVE, PMax, PMax, PMin, PMin);
    send_cmd(wpsteer_pkg::REQ_MOVE, PMin, PMin, PMax, PMax);
    send_cmd(wpsteer_pkg::REQ_MOVE, PMin, PMax, PMax, PMin);
    send_cmd(wpsteer_pkg::REQ_MOVE, PMax, PMin, PMin, PMax);
    send_cmd(wpsteer_pkg::REQ_MOVE, 32'h0001_0000, 0, 0, 0);
    send_cmd(wpsteer_pkg::REQ_MOVE, 32'hFFFF_0000, 0, 0, 0);
    send_cmd(wpsteer_pkg::REQ_MOVE, 0, 32'hFFFF_0000, 0, 0);
    send_cmd(wpsteer_pkg::REQ_MOVE, 100, 100, 0, 0);
    repeat (6) send_cmd(wpsteer_pkg::REQ_TURN, 32'hFFFF_0000, 32'h0000_0001, 0, 0);
    send_cmd(wpsteer_pkg::REQ_TURN, 32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0);

    // Extremes: fastest speed, tightest radius, no tolerance, smallest step.
    set_regs(31'h7FFF_FFFF, 31'd1, 15'd0, 15'd1);
    send_cmd(wpsteer_pkg::REQ_MOVE, 0, 0, 0, 0);
    send_cmd(wpsteer_pkg::REQ_MOVE, PMax, 0, PMin, 0);
    random_ticks(175);

    // Zero speed, largest radius, tolerance and step of pi.
    set_regs(31'd0, 31'h7FFF_FFFF, 15'd25736, 15'd25736);
    random_ticks(120);
    set_regs(31'($urandom), 31'd1, 15'd0, 15'd25736);
    repeat (4) send_cmd(wpsteer_pkg::REQ_TURN, PMin, 32'd1, 0, 0);
    random_ticks(120);

    set_regs(31'($urandom), 31'($urandom_range(1, 1 << 20)),
             15'($urandom_range(0, 25736)), 15'($urandom_range(1, 25736)));
    random_ticks(140);
    set_regs(31'd655360, 31'd655, 15'd410, 15'd819);
    random_ticks(120);

    quiesce();
    repeat (150) @(posedge clk_i);
    $display("covered %0d commands, %0d results checked, over 6 register settings",
             sent_cnt, checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/wpsteer_pkg.sv
rtl/wpsteer_stream_if.sv
rtl/waypoint_heading_steer.sv
tb/wpsteer_steer_checker.sv
tb/tb_waypoint_heading_steer.sv
